FILE: src/crc16_frame_parser_top_assert.svh
// Assertion macros for the CRC-16 frame parser.
// Included by crc16_frame_parser_top; uses clk_i and rst_ni of the includer.
`ifndef CRC16_FRAME_PARSER_TOP_ASSERT_SVH
`define CRC16_FRAME_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CFP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`define CFP_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);
`else
`define CFP_ASSERT_NEVER(lbl, cond, msg)
`define CFP_ASSERT_IMPLY(lbl, pre, post, msg)
`endif

`endif

FILE: src/crc16fp_pkg.sv
// Shared types, constants and CRC step function of the CRC-16 frame parser.
// No dependencies.
package crc16fp_pkg;

  localparam int          MaxPayloadDef  = 32;
  localparam int          LenW           = 6;
  localparam int          PosW           = 5;
  localparam int          QDepth         = 2;
  localparam int          QPtrW          = $clog2(QDepth);
  localparam logic [7:0]  StartMarkerRst = 8'd126;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPoly        = 16'hA001;

  typedef enum logic [1:0] {
    KindHdr = 2'd0,
    KindPay = 2'd1,
    KindErr = 2'd2
  } kind_e;

  typedef struct packed {
    logic            err;
    logic [7:0]      node;
    logic [7:0]      ftype;
    logic [LenW-1:0] len;
    logic [15:0]     chk;
  } cmd_t;

  typedef struct packed {
    logic            en;
    logic [LenW-1:0] idx;
    logic [7:0]      data;
  } wr_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      node;
    logic [7:0]      ftype;
    logic [LenW-1:0] len;
    logic [15:0]     chk;
    logic [7:0]      value;
    logic [PosW-1:0] pos;
    logic            last;
  } res_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c);
    crc_step = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
  endfunction

endpackage

FILE: src/crc16_frame_parser_top.sv
// Top level of the CRC-16/Modbus frame parser: config register, front end,
// command queue, back end. Depends on crc16fp_pkg and the crc16fp_* modules.
//
//   channel   dir  beat contents
//   s_axis    in   tdata = received byte
//   m_axis    out  tdata = node, type, length, check, value, position; tuser = kind
//   cfg       in   cfg_data_i = start marker byte
//
// Marker and hunting bytes take no extra time; after a node, type, length or payload
// byte, input waits until the one-bit-per-cycle CRC register has finished it.
// A good frame replays its payload from the payload RAM, one read per result.
// Payload bytes of a new frame stall while an earlier frame is still replayed.
// Reset is asynchronous, active low; no clearing pass.
`include "crc16_frame_parser_top_assert.svh"

module crc16_frame_parser_top import crc16fp_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,    // start_marker
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_node, frame_type, frame_length, received_check, payload_value,
  // payload_position, zero fill
  output logic [55:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast
);

  logic [7:0] marker_q;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  logic       back_busy;
  cmd_t       cmd_in;
  cmd_t       cmd_out;
  wr_t        wr;
  res_t       res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= StartMarkerRst;
    end else if (cfg_valid_i) begin
      marker_q <= cfg_data_i;
    end
  end

  crc16fp_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_marker_i(marker_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .back_busy_i   (back_busy),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd_in),
    .wr_o          (wr)
  );

  crc16fp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .din_i  (cmd_in),
    .pop_i  (pop),
    .dout_o (cmd_out),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  crc16fp_back #(
    .MaxPayload(MaxPayload)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .q_empty_i  (q_empty),
    .cmd_i      (cmd_out),
    .pop_o      (pop),
    .busy_o     (back_busy),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (res)
  );

  assign m_axis_tdata = {5'd0, res.pos, res.value, res.chk, res.len, res.ftype, res.node};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  `CFP_ASSERT_NEVER(a_no_wr_during_replay, wr.en && back_busy, "payload write during replay")
  `CFP_ASSERT_NEVER(a_no_push_full, push && q_full, "command push into full queue")
  `CFP_ASSERT_IMPLY(a_err_is_last, m_axis_tvalid && (m_axis_tuser == KindErr), m_axis_tlast, "error result not last")

endmodule

FILE: src/crc16fp_front.sv
// Front end: frame parser with bit-serial CRC-16, writes payload bytes and
// pushes one command per completed frame. Depends on crc16fp_pkg.
module crc16fp_front import crc16fp_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] start_marker_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       back_busy_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o,
  output wr_t        wr_o
);

  localparam logic [2:0] PhHunt = 3'd0;
  localparam logic [2:0] PhNode = 3'd1;
  localparam logic [2:0] PhType = 3'd2;
  localparam logic [2:0] PhLen  = 3'd3;
  localparam logic [2:0] PhData = 3'd4;
  localparam logic [2:0] PhChkh = 3'd5;
  localparam logic [2:0] PhChkl = 3'd6;

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      node_q, node_d;
  logic [7:0]      ftype_q, ftype_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [7:0]      chkh_q, chkh_d;
  logic [15:0]     crc_q, crc_d;
  logic [2:0]      steps_q, steps_d;
  logic            accept;
  logic [LenW-1:0] cnt_inc;
  logic [15:0]     crc_in;

  assign in_ready_o = (steps_q == 3'd0)
                    && !((phase_q == PhData) && back_busy_i)
                    && !((phase_q == PhChkl) && q_full_i);
  assign accept  = in_valid_i && in_ready_o;
  assign cnt_inc = cnt_q + LenW'(1);
  assign crc_in  = crc_step(crc_q ^ {8'h00, in_byte_i});

  assign cmd_o.err   = ({chkh_q, in_byte_i} != crc_q);
  assign cmd_o.node  = node_q;
  assign cmd_o.ftype = ftype_q;
  assign cmd_o.len   = len_q;
  assign cmd_o.chk   = {chkh_q, in_byte_i};

  always_comb begin
    phase_d   = phase_q;
    node_d    = node_q;
    ftype_d   = ftype_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    chkh_d    = chkh_q;
    crc_d     = crc_q;
    steps_d   = steps_q;
    push_o    = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.idx  = cnt_q;
    wr_o.data = in_byte_i;
    if (steps_q != 3'd0) begin
      crc_d   = crc_step(crc_q);
      steps_d = steps_q - 3'd1;
    end
    if (accept) begin
      unique case (phase_q)
        PhNode: begin
          node_d  = in_byte_i;
          crc_d   = crc_in;
          steps_d = 3'd7;
          phase_d = PhType;
        end
        PhType: begin
          ftype_d = in_byte_i;
          crc_d   = crc_in;
          steps_d = 3'd7;
          phase_d = PhLen;
        end
        PhLen: begin
          crc_d   = crc_in;
          steps_d = 3'd7;
          if (in_byte_i > 8'(MaxPayload)) begin
            phase_d = PhHunt;
          end else begin
            len_d   = in_byte_i[LenW-1:0];
            phase_d = (in_byte_i == 8'd0) ? PhChkh : PhData;
          end
        end
        PhData: begin
          wr_o.en = (cnt_q < LenW'(MaxPayload));
          cnt_d   = cnt_inc;
          crc_d   = crc_in;
          steps_d = 3'd7;
          if (cnt_inc >= len_q) begin
            phase_d = PhChkh;
          end
        end
        PhChkh: begin
          chkh_d  = in_byte_i;
          phase_d = PhChkl;
        end
        PhChkl: begin
          push_o  = 1'b1;
          phase_d = PhHunt;
        end
        default: begin
          phase_d = PhHunt;
          if (in_byte_i == start_marker_i) begin
            node_d  = 8'h00;
            ftype_d = 8'h00;
            len_d   = '0;
            cnt_d   = '0;
            chkh_d  = 8'h00;
            crc_d   = CrcInit;
            phase_d = PhNode;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      node_q  <= 8'h00;
      ftype_q <= 8'h00;
      len_q   <= '0;
      cnt_q   <= '0;
      chkh_q  <= 8'h00;
      crc_q   <= CrcInit;
      steps_q <= 3'd0;
    end else begin
      phase_q <= phase_d;
      node_q  <= node_d;
      ftype_q <= ftype_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      chkh_q  <= chkh_d;
      crc_q   <= crc_d;
      steps_q <= steps_d;
    end
  end

endmodule

FILE: src/crc16fp_queue.sv
// Short command FIFO between parser front end and result back end.
// Depends on crc16fp_pkg.
module crc16fp_queue import crc16fp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t din_i,
  input  logic pop_i,
  output cmd_t dout_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t             entries_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = entries_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPtrW+1)'(1);
      end
    end
  end

endmodule

FILE: src/crc16fp_back.sv
// Back end: payload memory and result sequencer with a registered output.
// Depends on crc16fp_pkg.
module crc16fp_back import crc16fp_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  wr_t  wr_i,
  input  logic q_empty_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic busy_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  localparam int AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  localparam logic [1:0] BIdle = 2'd0;
  localparam logic [1:0] BHead = 2'd1;
  localparam logic [1:0] BRead = 2'd2;
  localparam logic [1:0] BEmit = 2'd3;

  logic [7:0]      mem_q [MaxPayload];
  logic [7:0]      rd_q;
  logic            rd_en;
  logic [1:0]      st_q, st_d;
  cmd_t            cmd_q, cmd_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [LenW-1:0] idx_inc;
  res_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            head_last;
  logic            pay_last;

  assign out_free    = !out_valid_q || out_ready_i;
  assign idx_inc     = idx_q + LenW'(1);
  assign head_last   = cmd_q.err || (cmd_q.len == '0);
  assign pay_last    = (idx_inc == cmd_q.len);
  assign busy_o      = (st_q != BIdle) || !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx[AddrW-1:0]] <= wr_i.data;
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q[AddrW-1:0]];
    end
  end

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    unique case (st_q)
      BIdle: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          idx_d = '0;
          st_d  = BHead;
        end
      end
      BHead: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.kind  = cmd_q.err ? KindErr : KindHdr;
          out_d.node  = cmd_q.node;
          out_d.ftype = cmd_q.ftype;
          out_d.len   = cmd_q.len;
          out_d.chk   = cmd_q.chk;
          out_d.value = 8'h00;
          out_d.pos   = '0;
          out_d.last  = head_last;
          st_d        = head_last ? BIdle : BRead;
        end
      end
      BRead: begin
        rd_en = 1'b1;
        st_d  = BEmit;
      end
      BEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.kind  = KindPay;
          out_d.value = rd_q;
          out_d.pos   = idx_q[PosW-1:0];
          out_d.last  = pay_last;
          idx_d       = idx_inc;
          st_d        = pay_last ? BIdle : BRead;
        end
      end
      default: begin
        st_d = BIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BIdle;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

endmodule

FILE: test/crc16_frame_parser_check.sv
// Scoreboard for crc16_frame_parser_top: watches the config, input and result
// channels, predicts the parser's results and compares them beat by beat.
// Depends on crc16fp_pkg.
module crc16_frame_parser_check import crc16fp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          mismatches_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PhHunt, PhNode, PhType, PhLen, PhData, PhChkHi, PhChkLo
  } parse_phase_e;

  logic [7:0]   marker;
  parse_phase_e phase;
  logic [7:0]   node, ftype, chk_hi;
  logic [5:0]   len, count;
  logic [7:0]   payload [MaxPayloadDef];
  logic [15:0]  crc;
  res_t         frame_results [$];

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    res_t r;
    case (phase)
      PhNode: begin
        node  = b;
        crc   = crc16_update(crc, b);
        phase = PhType;
      end
      PhType: begin
        ftype = b;
        crc   = crc16_update(crc, b);
        phase = PhLen;
      end
      PhLen: begin
        crc = crc16_update(crc, b);
        if (b > MaxPayloadDef) begin
          phase = PhHunt;
        end else begin
          len   = b[5:0];
          phase = (b == 8'd0) ? PhChkHi : PhData;
        end
      end
      PhData: begin
        if (count < MaxPayloadDef) payload[count[4:0]] = b;
        count = count + 6'd1;
        crc   = crc16_update(crc, b);
        if (count >= len) phase = PhChkHi;
      end
      PhChkHi: begin
        chk_hi = b;
        phase  = PhChkLo;
      end
      PhChkLo: begin
        phase   = PhHunt;
        r.node  = node;
        r.ftype = ftype;
        r.len   = len;
        r.chk   = {chk_hi, b};
        r.value = 8'd0;
        r.pos   = '0;
        if (r.chk != crc) begin
          r.kind = KindErr;
          r.last = 1'b1;
          frame_results.push_back(r);
        end else begin
          r.kind = KindHdr;
          r.last = (len == 6'd0);
          frame_results.push_back(r);
          for (int i = 0; i < len && i < MaxPayloadDef; i++) begin
            r.kind  = KindPay;
            r.value = payload[i];
            r.pos   = PosW'(i);
            r.last  = (i + 1 == len);
            frame_results.push_back(r);
          end
        end
      end
      default: begin
        phase = PhHunt;
        if (b == marker) begin
          node   = '0;
          ftype  = '0;
          len    = '0;
          count  = '0;
          chk_hi = '0;
          crc    = CrcInit;
          phase  = PhNode;
        end
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (mismatches_o < 50) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatches_o++;
  endtask

  task automatic check_result();
    res_t want;
    if (frame_results.size() == 0) begin
      report("result beat with none expected", 64'(m_tdata_i), 64'(0));
    end else begin
      want = frame_results.pop_front();
      if (m_tuser_i != want.kind)
        report("kind", 64'(m_tuser_i), 64'(want.kind));
      if (m_tdata_i[7:0] != want.node)
        report("node", 64'(m_tdata_i[7:0]), 64'(want.node));
      if (m_tdata_i[15:8] != want.ftype)
        report("type", 64'(m_tdata_i[15:8]), 64'(want.ftype));
      if (m_tdata_i[21:16] != want.len)
        report("length", 64'(m_tdata_i[21:16]), 64'(want.len));
      if (m_tdata_i[37:22] != want.chk)
        report("check", 64'(m_tdata_i[37:22]), 64'(want.chk));
      if (m_tdata_i[45:38] != want.value)
        report("value", 64'(m_tdata_i[45:38]), 64'(want.value));
      if (m_tdata_i[50:46] != want.pos)
        report("position", 64'(m_tdata_i[50:46]), 64'(want.pos));
      if (m_tdata_i[55:51] != '0)
        report("fill bits", 64'(m_tdata_i[55:51]), 64'(0));
      if (m_tlast_i != want.last)
        report("last", 64'(m_tlast_i), 64'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker = StartMarkerRst;
      phase  = PhHunt;
      node   = '0;
      ftype  = '0;
      len    = '0;
      count  = '0;
      chk_hi = '0;
      crc    = CrcInit;
      frame_results.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      // a result beat never belongs to the byte taken on the same edge
      if (m_tvalid_i && m_tready_i) check_result();
      // a byte taken on a marker write edge still sees the old marker
      if (s_tvalid_i && s_tready_i) parse_byte(s_tdata_i);
      if (cfg_valid_i && cfg_ready_i) marker = cfg_data_i;
      pending_o = frame_results.size();
    end
  end

endmodule

FILE: test/crc16_frame_parser_top_tb.sv
// Testbench top for crc16_frame_parser_top: clock, reset, frame stimulus,
// result-side backpressure and verdict. Depends on crc16fp_pkg,
// crc16_frame_parser_check and the parser RTL.
module crc16_frame_parser_top_tb import crc16fp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 32;

  logic        clk = 1'b0;
  logic        rst_n = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int          mismatches;
  int          pending;
  int          cycles = 0;
  int          sent = 0;
  int          hold_req = 0;
  bit          calm = 1'b0;
  logic [7:0]  marker = StartMarkerRst;
  logic [7:0]  payload_bytes [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  crc16_frame_parser_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  crc16_frame_parser_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
  endtask

  // frame around payload_bytes; flip corrupts the sent check
  task automatic send_frame(input logic [7:0] node, input logic [7:0] ftype,
                            input logic [15:0] flip);
    logic [15:0] crc;
    logic [7:0]  len;
    len = 8'(payload_bytes.size());
    crc = crc16_update(crc16_update(crc16_update(CrcInit, node), ftype), len);
    foreach (payload_bytes[i]) crc = crc16_update(crc, payload_bytes[i]);
    crc ^= flip;
    send_byte(marker);
    send_byte(node);
    send_byte(ftype);
    send_byte(len);
    foreach (payload_bytes[i]) send_byte(payload_bytes[i]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  task automatic random_payload(input int len);
    payload_bytes.delete();
    repeat (len) payload_bytes.push_back(8'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_marker(input logic [7:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    marker = value;
  endtask

  task automatic random_traffic(input int n_bytes);
    int stop;
    int pick;
    int sel;
    int len;
    stop = sent + n_bytes;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        sel = $urandom_range(0, 15);
        if (sel == 0)      len = 0;
        else if (sel == 1) len = MaxPayloadDef;
        else if (sel == 2) len = $urandom_range(17, MaxPayloadDef - 1);
        else               len = $urandom_range(1, 8);
        random_payload(len);
        send_frame(8'($urandom), 8'($urandom),
                   ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0);
      end else if (pick < 84) begin
        send_byte(8'($urandom));
      end else if (pick < 92) begin
        send_byte(marker);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(8'($urandom_range(MaxPayloadDef + 1, 255)));
      end else begin
        send_byte(marker);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls per beat, plus long hold-offs on request
  initial begin
    int stall;
    int holds_done;
    holds_done = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req > holds_done) begin
        stall = HoldCycles;
        holds_done++;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    rst_n <= 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: ignored noise, empty frame, oversize length, bad check with
    // the marker inside the payload, good frame with extreme payload bytes
    send_byte(8'h00);
    send_byte(8'hFF);
    payload_bytes.delete();
    send_frame(8'h00, 8'hFF, 16'h0000);
    send_byte(marker);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'(MaxPayloadDef + 1));
    payload_bytes = '{StartMarkerRst};
    send_frame(8'hFF, 8'h00, 16'h0001);
    payload_bytes = '{8'h00, 8'hFF};
    send_frame(8'h80, 8'h01, 16'h0000);
    drain();

    write_marker(8'h00);
    random_traffic(80);
    drain();

    write_marker(8'hFF);
    calm = 1'b1;
    random_traffic(40);
    // block the result side while good frames keep coming
    hold_req++;
    repeat (3) begin
      random_payload($urandom_range(12, 20));
      send_frame(8'($urandom), 8'($urandom), 16'h0);
    end
    calm = 1'b0;
    drain();
    random_traffic(30);
    drain();

    write_marker(8'($urandom));
    random_traffic(70);
    drain();

    write_marker(StartMarkerRst);
    random_traffic(60);
    drain();

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/crc16fp_pkg.sv
src/crc16fp_front.sv
src/crc16fp_queue.sv
src/crc16fp_back.sv
src/crc16_frame_parser_top.sv
test/crc16_frame_parser_check.sv
test/crc16_frame_parser_top_tb.sv
